// ===== rtl/decimal96_to_text_defines.svh =====
// Assertion macros shared by the checker files.
`ifndef DECIMAL96_TO_TEXT_DEFINES_SVH
`define DECIMAL96_TO_TEXT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define D96T_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define D96T_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/d96t_pkg.sv =====
package d96t_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned MANT_W  = 3 * WORD_W;
  localparam int unsigned NDIG    = 29;
  localparam int unsigned BCD_W   = 4 * NDIG;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned NDIG_W  = 5;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned CNT_W   = 7;

  localparam logic [SCALE_W-1:0] SCALE_MAX  = 5'd28;
  localparam logic [NDIG_W-1:0]  NDIG_FULL  = 5'd29;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0]  CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0]  CHAR_POINT = 7'h2E;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 7'h2D;

  // Requests from the text sequencer and the top level to the converter
  typedef struct packed {
    logic start;
    logic dig_shift;
    logic done_ack;
  } conv_ctrl_t;

  // Converter status toward the text sequencer and the top level
  typedef struct packed {
    logic              idle;
    logic              done;
    logic [3:0]        top_digit;
    logic [NDIG_W-1:0] ndig;
  } conv_stat_t;

  // Emitter requests back to the converter
  typedef struct packed {
    logic dig_shift;
    logic done_ack;
  } emit_req_t;

endpackage

// ===== rtl/d96t_in_if.sv =====
interface d96t_in_if;
  import d96t_pkg::*;

  logic               valid;
  logic               ready;
  logic [WORD_W-1:0]  mantissa_lo;
  logic [WORD_W-1:0]  mantissa_mid;
  logic [WORD_W-1:0]  mantissa_hi;
  logic [SCALE_W-1:0] scale;
  logic               negative;

  modport source (
    output valid, mantissa_lo, mantissa_mid, mantissa_hi, scale, negative,
    input  ready
  );
  modport sink (
    input  valid, mantissa_lo, mantissa_mid, mantissa_hi, scale, negative,
    output ready
  );
endinterface

// ===== rtl/d96t_out_if.sv =====
interface d96t_out_if;
  import d96t_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (
    output valid, out_char, last_char,
    input  ready
  );
  modport sink (
    input  valid, out_char, last_char,
    output ready
  );
endinterface

// ===== rtl/d96t_bcd_conv.sv =====
module d96t_bcd_conv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  d96t_pkg::conv_ctrl_t              ctrl_i,
  input  logic [d96t_pkg::MANT_W-1:0]       mant_i,
  output d96t_pkg::conv_stat_t              stat_o
);
  import d96t_pkg::*;

  typedef enum logic [3:0] {
    CV_IDLE = 4'b0001,
    CV_CONV = 4'b0010,
    CV_NORM = 4'b0100,
    CV_HOLD = 4'b1000
  } cv_state_e;

  cv_state_e          state_q, state_d;
  logic [MANT_W-1:0]  bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [NDIG_W-1:0]  ndig_q, ndig_d;
  logic               norm_shift;

  // Add three to every digit of five or more before the next shift
  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      bcd_adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? bcd_q[4*k +: 4] + 4'd3
                                                     : bcd_q[4*k +: 4];
    end
  end

  // Drop leading zero digits, keeping at least one
  assign norm_shift = (ndig_q > NDIG_W'(1)) && (bcd_q[BCD_W-1 -: 4] == 4'd0);

  always_comb begin
    state_d = state_q;
    bin_d   = bin_q;
    bcd_d   = bcd_q;
    cnt_d   = cnt_q;
    ndig_d  = ndig_q;
    unique case (state_q)
      CV_IDLE: begin
        if (ctrl_i.start) begin
          bin_d   = mant_i;
          bcd_d   = '0;
          cnt_d   = CNT_W'(MANT_W - 1);
          state_d = CV_CONV;
        end
      end
      CV_CONV: begin
        // Shift one magnitude bit into the digit register
        bcd_d = {bcd_adj[BCD_W-2:0], bin_q[MANT_W-1]};
        bin_d = {bin_q[MANT_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          ndig_d  = NDIG_FULL;
          state_d = CV_NORM;
        end
      end
      CV_NORM: begin
        if (norm_shift) begin
          bcd_d  = {bcd_q[BCD_W-5:0], 4'd0};
          ndig_d = ndig_q - NDIG_W'(1);
        end else begin
          state_d = CV_HOLD;
        end
      end
      CV_HOLD: begin
        // Advance to the next digit as the sequencer consumes one
        if (ctrl_i.dig_shift) begin
          bcd_d = {bcd_q[BCD_W-5:0], 4'd0};
        end
        if (ctrl_i.done_ack) begin
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CV_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    ndig_q <= ndig_d;
  end

  assign stat_o.idle      = (state_q == CV_IDLE);
  assign stat_o.done      = (state_q == CV_NORM) && !norm_shift;
  assign stat_o.top_digit = bcd_q[BCD_W-1 -: 4];
  assign stat_o.ndig      = ndig_q;

endmodule

// ===== rtl/d96t_emitter.sv =====
module d96t_emitter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  d96t_pkg::conv_stat_t              stat_i,
  input  logic [d96t_pkg::SCALE_W-1:0]      scale_i,
  input  logic                              negative_i,
  output d96t_pkg::emit_req_t               req_o,
  output logic                              idle_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [d96t_pkg::CHAR_W-1:0]       out_char_o,
  output logic                              last_char_o
);
  import d96t_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MINUS  = 6'b000010,
    S_LEAD0  = 6'b000100,
    S_LEADPT = 6'b001000,
    S_ZEROS  = 6'b010000,
    S_DIGITS = 6'b100000
  } em_state_e;

  em_state_e          state_q, state_d;
  logic [NDIG_W-1:0]  rem_q, rem_d;
  logic [SCALE_W-1:0] scl_q, scl_d;
  logic [SCALE_W-1:0] zcnt_q, zcnt_d;
  logic               pt_q, pt_d;
  logic               big_q, big_d;
  logic               ov_q, ov_d;
  logic [CHAR_W-1:0]  ch_q, ch_d;
  logic               last_q, last_d;
  logic [SCALE_W-1:0] scl_sat;
  logic               big_new;
  logic               adv;
  logic [CHAR_W-1:0]  ch_new;
  logic               last_new;

  assign scl_sat = (scale_i > SCALE_MAX) ? SCALE_MAX : scale_i;
  assign big_new = (stat_i.ndig > NDIG_W'(scl_sat));
  assign adv     = (state_q != S_IDLE) && (!ov_q || out_ready_i);

  always_comb begin
    state_d       = state_q;
    rem_d         = rem_q;
    scl_d         = scl_q;
    zcnt_d        = zcnt_q;
    pt_d          = pt_q;
    big_d         = big_q;
    ch_new        = CHAR_ZERO;
    last_new      = 1'b0;
    req_o         = '0;
    unique case (state_q)
      S_IDLE: begin
        // Load the layout of the next number once its digits are ready
        if (stat_i.done) begin
          rem_d   = stat_i.ndig;
          scl_d   = scl_sat;
          big_d   = big_new;
          pt_d    = big_new && (scl_sat != '0);
          zcnt_d  = scl_sat - SCALE_W'(stat_i.ndig);
          if (negative_i) begin
            state_d = S_MINUS;
          end else if (big_new) begin
            state_d = S_DIGITS;
          end else begin
            state_d = S_LEAD0;
          end
        end
      end
      S_MINUS: begin
        ch_new = CHAR_MINUS;
        if (adv) begin
          state_d = big_q ? S_DIGITS : S_LEAD0;
        end
      end
      S_LEAD0: begin
        ch_new = CHAR_ZERO;
        if (adv) begin
          state_d = S_LEADPT;
        end
      end
      S_LEADPT: begin
        ch_new = CHAR_POINT;
        if (adv) begin
          state_d = (zcnt_q != '0) ? S_ZEROS : S_DIGITS;
        end
      end
      S_ZEROS: begin
        ch_new = CHAR_ZERO;
        if (adv) begin
          zcnt_d = zcnt_q - SCALE_W'(1);
          if (zcnt_q == SCALE_W'(1)) begin
            state_d = S_DIGITS;
          end
        end
      end
      S_DIGITS: begin
        if (pt_q && (rem_q == NDIG_W'(scl_q))) begin
          ch_new = CHAR_POINT;
          if (adv) begin
            pt_d = 1'b0;
          end
        end else begin
          ch_new   = CHAR_ZERO | {3'b000, stat_i.top_digit};
          last_new = (rem_q == NDIG_W'(1));
          if (adv) begin
            req_o.dig_shift = 1'b1;
            rem_d           = rem_q - NDIG_W'(1);
            if (last_new) begin
              req_o.done_ack = 1'b1;
              state_d        = S_IDLE;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the character until taken, refill on advance
  always_comb begin
    ov_d   = ov_q;
    ch_d   = ch_q;
    last_d = last_q;
    if (adv) begin
      ov_d   = 1'b1;
      ch_d   = ch_new;
      last_d = last_new;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    scl_q  <= scl_d;
    zcnt_q <= zcnt_d;
    pt_q   <= pt_d;
    big_q  <= big_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_char_o  = ch_q;
  assign last_char_o = last_q;

endmodule

// ===== rtl/decimal96_to_text.sv =====
// decimal96_to_text: prints a scaled 96-bit decimal as ASCII text.
// Input channel in_s carries the magnitude in three 32-bit words, a scale
// (digits right of the point, values above 28 clamp to 28) and a sign.
// Output channel out_s gives one character per transaction ('0'..'9',
// '.', '-'); last_char marks the final character of a number.
// A number is converted by a bit-serial shift-and-add-3 loop, then
// 0 to 28 leading zero digits are stripped, one per cycle.
// Characters then follow one per cycle while the receiver is ready,
// 1 to 31 characters per number.
// One number is worked on at a time: in_s.ready rises again once the
// last character sits in the output register, so a new number is taken
// while that character still waits.
// A stalled receiver holds the current character and pauses the text.
// Reset empties the output register and returns both the converter and
// the text sequencer to idle; nothing else needs clearing.
module decimal96_to_text (
  input  logic  clk_i,
  input  logic  rst_ni,
  d96t_in_if.sink    in_s,
  d96t_out_if.source out_s
);
  import d96t_pkg::*;

  conv_ctrl_t         conv_ctrl;
  conv_stat_t         conv_stat;
  emit_req_t          emit_req;
  logic               emit_idle;
  logic               in_accept;
  logic [SCALE_W-1:0] scale_q;
  logic               neg_q;

  assign in_s.ready = conv_stat.idle && emit_idle;
  assign in_accept  = in_s.valid && in_s.ready;

  // Hold scale and sign for the text sequencer
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      scale_q <= in_s.scale;
      neg_q   <= in_s.negative;
    end
  end

  assign conv_ctrl.start     = in_accept;
  assign conv_ctrl.dig_shift = emit_req.dig_shift;
  assign conv_ctrl.done_ack  = emit_req.done_ack;

  d96t_bcd_conv u_conv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (conv_ctrl),
    .mant_i ({in_s.mantissa_hi, in_s.mantissa_mid, in_s.mantissa_lo}),
    .stat_o (conv_stat)
  );

  d96t_emitter u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stat_i      (conv_stat),
    .scale_i     (scale_q),
    .negative_i  (neg_q),
    .req_o       (emit_req),
    .idle_o      (emit_idle),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .out_char_o  (out_s.out_char),
    .last_char_o (out_s.last_char)
  );

endmodule

// ===== rtl/d96t_checker.sv =====
`include "decimal96_to_text_defines.svh"

module d96t_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [d96t_pkg::CHAR_W-1:0] out_char_i,
  input  logic                        last_char_i
);
  import d96t_pkg::*;

  logic busy_q;
  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track a number whose final character has not been taken yet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
    end else if (out_acc && last_char_i) begin
      busy_q <= 1'b0;
    end
  end

  `D96T_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_char_i) && $stable(last_char_i), "stalled character changed")
  `D96T_ASSERT_IMP(a_one_number, in_acc, !busy_q || (out_valid_i && last_char_i), "new number taken before previous text finished")
  `D96T_ASSERT_NXT(a_ready_drop, in_acc, !in_ready_i, "ready stayed high after a number was taken")
  `D96T_ASSERT_IMP(a_char_set, out_valid_i, ((out_char_i >= CHAR_ZERO) && (out_char_i <= CHAR_NINE)) || (out_char_i == CHAR_POINT) || (out_char_i == CHAR_MINUS), "character outside digit, point, minus")

endmodule

bind decimal96_to_text d96t_checker u_d96t_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_s.valid),
  .in_ready_i  (in_s.ready),
  .out_valid_i (out_s.valid),
  .out_ready_i (out_s.ready),
  .out_char_i  (out_s.out_char),
  .last_char_i (out_s.last_char)
);

// ===== tb/decimal96_to_text_test.sv =====
module decimal96_to_text_test;
  import d96t_pkg::*;

  localparam int unsigned RANDOM_NUMBERS = 430;
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned TAIL_CYCLES    = 200;

  // One expected character of the printed text
  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic              last;
  } text_char_t;

  // One directed number; an empty text means the predictor supplies it
  typedef struct {
    logic [MANT_W-1:0]  mag;
    logic [SCALE_W-1:0] scale;
    logic               neg;
    string              text;
  } number_row_t;

  logic clk;
  logic rst_n;
  logic burst_mode;
  logic hold_req;
  int   fault_cnt = 0;

  text_char_t  text_q[$];
  number_row_t plan_q[$];

  d96t_in_if  in_ch ();
  d96t_out_if out_ch ();

  decimal96_to_text dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_s   (in_ch),
    .out_s  (out_ch)
  );

  // Generate the clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End a hung run
  initial begin
    #2_500_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Queue the characters of one text, marking the final one
  function automatic void push_text(string text);
    byte        b;
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      b = text[i];
      c.chr = b[CHAR_W-1:0];
      c.last = (i == text.len() - 1);
      text_q.push_back(c);
    end
  endfunction

  // Render a scaled decimal the way the block prints it
  function automatic void predict_text(logic [MANT_W-1:0] mag, logic [SCALE_W-1:0] scale,
                                       logic neg);
    logic [MANT_W-1:0] rest;
    string             digits;
    string             text;
    int                ndig;
    int                places;
    rest = mag;
    digits = "";
    text = "";
    places = (scale > SCALE_MAX) ? int'(SCALE_MAX) : int'(scale);
    // peel digits off the bottom, at least one
    do begin
      digits = $sformatf("%0d%s", rest % 10, digits);
      rest = rest / 10;
    end while (rest != 0 && digits.len() < 30);
    ndig = digits.len();
    if (neg) text = "-";
    if (ndig > places) begin
      for (int i = 0; i < ndig; i++) begin
        if (places != 0 && ndig - i == places) text = {text, "."};
        text = $sformatf("%s%c", text, digits[i]);
      end
    end else begin
      text = {text, "0."};
      for (int i = ndig; i < places; i++) text = {text, "0"};
      text = {text, digits};
    end
    push_text(text);
  endfunction

  function automatic logic [MANT_W-1:0] pow_ten(int k);
    logic [MANT_W-1:0] p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Pick a magnitude from a mix of digit counts and bit patterns
  function automatic logic [MANT_W-1:0] rand_mag();
    logic [MANT_W-1:0] full;
    int                k;
    full = {$urandom(), $urandom(), $urandom()};
    k = $urandom_range(1, 28);
    case ($urandom_range(0, 5))
      0: return full;
      1: return {64'd0, full[WORD_W-1:0]};
      2: return {32'd0, full[2*WORD_W-1:0]};
      3: return full % pow_ten(k);
      4: return ($urandom_range(0, 1) != 0) ? pow_ten(k) : pow_ten(k) - 1;
      default: return MANT_W'($urandom_range(0, 20));
    endcase
  endfunction

  function automatic void add_row(logic [MANT_W-1:0] mag, logic [SCALE_W-1:0] scale,
                                  logic neg, string text);
    number_row_t r;
    r.mag = mag;
    r.scale = scale;
    r.neg = neg;
    r.text = text;
    plan_q.push_back(r);
  endfunction

  // Offer one number, wait for its transaction, then record its text
  task automatic offer_number(logic [MANT_W-1:0] mag, logic [SCALE_W-1:0] scale,
                              logic neg, string text);
    while (!burst_mode && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.mantissa_lo  <= mag[WORD_W-1:0];
    in_ch.mantissa_mid <= mag[2*WORD_W-1:WORD_W];
    in_ch.mantissa_hi  <= mag[MANT_W-1:2*WORD_W];
    in_ch.scale        <= scale;
    in_ch.negative     <= neg;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (text.len() == 0) predict_text(mag, scale, neg);
    else push_text(text);
  endtask

  // Drive the receiver: random stalls, a stall-free stretch, one long hold-off
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ch.ready <= burst_mode || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Check each character transaction against the oldest expectation
  always @(posedge clk) begin : text_check
    text_char_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_q.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual %h last %b",
                 $time, out_ch.out_char, out_ch.last_char);
        fault_cnt++;
      end else begin
        want = text_q.pop_front();
        if (want.chr !== out_ch.out_char || want.last !== out_ch.last_char) begin
          $display("%0t: char mismatch: expected %h last %b, actual %h last %b",
                   $time, want.chr, want.last, out_ch.out_char, out_ch.last_char);
          fault_cnt++;
        end
      end
    end
  end

  // Main sequence: reset, directed numbers, random numbers, drain
  initial begin
    logic [MANT_W-1:0] max_mag;
    rst_n              <= 1'b0;
    burst_mode         <= 1'b0;
    hold_req           <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.mantissa_lo  <= '0;
    in_ch.mantissa_mid <= '0;
    in_ch.mantissa_hi  <= '0;
    in_ch.scale        <= '0;
    in_ch.negative     <= 1'b0;
    max_mag = '1;

    add_row(0, 0, 1'b0, "0");
    add_row(0, 0, 1'b1, "-0");
    add_row(0, 2, 1'b1, "-0.00");
    add_row(1, 1, 1'b0, "0.1");
    add_row(12345, 2, 1'b0, "123.45");
    add_row(12345, 4, 1'b0, "1.2345");
    add_row(12345, 5, 1'b0, "0.12345");
    add_row(5, 3, 1'b0, "0.005");
    add_row(9, 0, 1'b1, "-9");
    add_row(max_mag, 0, 1'b0, "79228162514264337593543950335");
    add_row(max_mag, 28, 1'b1, "-7.9228162514264337593543950335");
    add_row(max_mag, 31, 1'b0, "7.9228162514264337593543950335");
    add_row(96'h1_0000_0000, 0, 1'b0, "4294967296");
    add_row(96'h1_0000_0000_0000_0000, 0, 1'b0, "18446744073709551616");
    add_row(1, 28, 1'b0, "");
    add_row(1, 29, 1'b1, "");
    add_row(0, 28, 1'b1, "");
    add_row(100, 30, 1'b0, "");
    add_row(96'd10000000000000000000000000000, 27, 1'b0, "");
    add_row(96'hFFFF_FFFF, 10, 1'b1, "");
    add_row(96'hAAAA_AAAA_AAAA_AAAA_AAAA_AAAA, 15, 1'b0, "");
    add_row(96'h5555_5555_5555_5555_5555_5555, 7, 1'b1, "");

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed rows
    foreach (plan_q[i]) offer_number(plan_q[i].mag, plan_q[i].scale, plan_q[i].neg,
                                     plan_q[i].text);

    // Random numbers, with a stall-free stretch and a receiver hold-off
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      if (n == 150) burst_mode <= 1'b1;
      if (n == 230) burst_mode <= 1'b0;
      if (n == 320) hold_req <= 1'b1;
      offer_number(rand_mag(),
                   ($urandom_range(0, 99) < 8) ? SCALE_W'($urandom_range(29, 31))
                                               : SCALE_W'($urandom_range(0, 28)),
                   1'($urandom_range(0, 1)), "");
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow for stray characters
    while (text_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fault_cnt == 0 && text_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
